[src/rhc_pkg.sv]
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants for the RGB to HSL converter
// Holds the record passed from cell to cell along the division chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  localparam int CHAN_W  = 8;
  localparam int LIGHT_W = 9;
  localparam int HNUM_W  = 11;   // hue numerator / divisor, up to 6*255
  localparam int SREM_W  = 9;    // saturation remainder / divisor, up to 255
  localparam int QUO_W   = 16;   // quotient bits, one per cell
  localparam int STEPS   = QUO_W;

  localparam logic [LIGHT_W-1:0] LIGHT_HALF = 9'd255;
  localparam logic [LIGHT_W-1:0] LIGHT_FULL = 9'd510;

  typedef struct packed {
    logic               gray;
    logic [LIGHT_W-1:0] light;
    logic [HNUM_W-1:0]  hrem;
    logic [HNUM_W-1:0]  hdiv;
    logic [QUO_W-1:0]   hquo;
    logic [SREM_W-1:0]  srem;
    logic [SREM_W-1:0]  sden;
    logic [QUO_W-1:0]   slow;    // dividend bits not yet shifted in
    logic [QUO_W-1:0]   squo;
  } rhc_cell_t;

endpackage

`default_nettype wire

[src/rhc_front.sv]
// ----------------------------------------------------------------------------
// rhc_front: channel extremes, hue numerator and divisors
// Registers the first record of the chain from the incoming pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_vld,
  input  wire logic [rhc_pkg::CHAN_W-1:0] red,
  input  wire logic [rhc_pkg::CHAN_W-1:0] green,
  input  wire logic [rhc_pkg::CHAN_W-1:0] blue,
  output logic                           out_vld,
  output rhc_pkg::rhc_cell_t             out_cell
);
  import rhc_pkg::*;

  logic [CHAN_W-1:0]  mx, mn, d;
  logic [LIGHT_W-1:0] light;
  logic [HNUM_W-1:0]  r_x, g_x, b_x, d_x, num, div6;
  logic [23:0]        sat_num;
  rhc_cell_t          cell_nxt, cell_r;
  logic               vld_r;

  always_comb begin
    mx = (red > green) ? red : green;
    if (blue > mx) mx = blue;
    mn = (red < green) ? red : green;
    if (blue < mn) mn = blue;
    d     = mx - mn;
    light = {1'b0, mx} + {1'b0, mn};
    r_x   = {3'b0, red};
    g_x   = {3'b0, green};
    b_x   = {3'b0, blue};
    d_x   = {3'b0, d};
    div6  = (d_x << 2) + (d_x << 1);
    // numerator always lands in [0, 6d); intermediate wrap is harmless
    if (mx == red) begin
      if (green < blue) num = div6 - (b_x - g_x);
      else num = g_x - b_x;
    end else if (mx == green) begin
      num = (d_x << 1) + b_x - r_x;
    end else begin
      num = (d_x << 2) + r_x - g_x;
    end
    sat_num = {d, 16'b0} - {16'b0, d};   // d * 65535

    cell_nxt.gray  = (mx == mn);
    cell_nxt.light = light;
    cell_nxt.hrem  = num;
    cell_nxt.hdiv  = div6;
    cell_nxt.hquo  = '0;
    cell_nxt.srem  = {1'b0, sat_num[23:16]};
    cell_nxt.sden  = (light > LIGHT_HALF) ? (LIGHT_FULL - light) : light;
    cell_nxt.slow  = sat_num[15:0];
    cell_nxt.squo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_cell = cell_r;

endmodule

`default_nettype wire

[src/rhc_div_cell.sv]
// ----------------------------------------------------------------------------
// rhc_div_cell: one restoring division step for hue and saturation
// Produces one quotient bit of each lane and hands the record onward.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_vld,
  input  rhc_pkg::rhc_cell_t      in_cell,
  output logic                    out_vld,
  output rhc_pkg::rhc_cell_t      out_cell
);
  import rhc_pkg::*;

  logic [HNUM_W:0] hsh, hdiff;
  logic [SREM_W:0] ssh, sdiff;
  logic            hge, sge;
  rhc_cell_t       cell_nxt, cell_r;
  logic            vld_r;

  always_comb begin
    hsh   = {in_cell.hrem, 1'b0};
    hdiff = hsh - {1'b0, in_cell.hdiv};
    hge   = (hsh >= {1'b0, in_cell.hdiv});
    ssh   = {in_cell.srem, in_cell.slow[QUO_W-1]};
    sdiff = ssh - {1'b0, in_cell.sden};
    sge   = (ssh >= {1'b0, in_cell.sden});

    cell_nxt      = in_cell;
    cell_nxt.hrem = hge ? hdiff[HNUM_W-1:0] : hsh[HNUM_W-1:0];
    cell_nxt.hquo = {in_cell.hquo[QUO_W-2:0], hge};
    cell_nxt.srem = sge ? sdiff[SREM_W-1:0] : ssh[SREM_W-1:0];
    cell_nxt.slow = {in_cell.slow[QUO_W-2:0], 1'b0};
    cell_nxt.squo = {in_cell.squo[QUO_W-2:0], sge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_cell = cell_r;

endmodule

`default_nettype wire

[src/rgb_to_hsl_convert.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert: 8-bit RGB to fixed-point HSL
// Front stage plus a chain of sixteen long-division cells.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while in_ready is high, returns one result
// per pixel, in order. One front stage finds max/min and forms the
// dividends and divisors, then sixteen cells each produce one bit of
// the hue and saturation quotients. The whole chain advances together and
// holds while a finished result is waiting on out_ready, so in_ready
// follows out_ready whenever the last stage is full. Hue is in 1/65536
// turn, saturation scaled to 65535 (both truncated, 0 for gray pixels),
// lightness is max+min.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_convert (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rhc_pkg::CHAN_W-1:0]  in_red,
  input  wire logic [rhc_pkg::CHAN_W-1:0]  in_green,
  input  wire logic [rhc_pkg::CHAN_W-1:0]  in_blue,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rhc_pkg::QUO_W-1:0]        out_hue,
  output logic [rhc_pkg::QUO_W-1:0]        out_saturation,
  output logic [rhc_pkg::LIGHT_W-1:0]      out_lightness
);
  import rhc_pkg::*;

  logic      adv;
  logic      vld [0:STEPS];
  rhc_cell_t stage [0:STEPS];

  // the chain moves whenever the last stage is empty or being drained
  assign adv      = !vld[STEPS] || out_ready;
  assign in_ready = adv;

  rhc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (in_valid),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .out_vld  (vld[0]),
    .out_cell (stage[0])
  );

  for (genvar i = 1; i <= STEPS; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (vld[i-1]),
      .in_cell  (stage[i-1]),
      .out_vld  (vld[i]),
      .out_cell (stage[i])
    );
  end

  assign out_valid      = vld[STEPS];
  assign out_hue        = stage[STEPS].gray ? '0 : stage[STEPS].hquo;
  assign out_saturation = stage[STEPS].gray ? '0 : stage[STEPS].squo;
  assign out_lightness  = stage[STEPS].light;

endmodule

`default_nettype wire
